[rtl/core/sip_pkg.sv]
package sip_pkg;

    // Fixed widths of the channel payload fields
    localparam int FIELD_W = 16;
    localparam int POINT_W = 32;

    // Number of endpoint coordinates in one request
    localparam int NUM_COORDS = 8;

endpackage

[rtl/core/sip_if.sv]
interface sip_req_if
    import sip_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] a_start_x;
    logic [FIELD_W-1:0] a_start_y;
    logic [FIELD_W-1:0] a_end_x;
    logic [FIELD_W-1:0] a_end_y;
    logic [FIELD_W-1:0] b_start_x;
    logic [FIELD_W-1:0] b_start_y;
    logic [FIELD_W-1:0] b_end_x;
    logic [FIELD_W-1:0] b_end_y;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

interface sip_rsp_if
    import sip_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic               found;
    logic [POINT_W-1:0] point_x;
    logic [POINT_W-1:0] point_y;

    modport source (
        output valid, found, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, found, point_x, point_y,
        output ready
    );
endinterface

[rtl/core/segment_intersection_point_core.sv]
// Exact 2D segment intersection. Each request carries two segments as signed
// integer endpoints (low COORD_BITS bits of each field); the response gives
// found plus the crossing point in signed fixed point with FRAC_BITS fraction
// bits, floored and saturated to 32 bits, or zero when the segments are
// parallel, collinear or miss. A shared endpoint is returned exactly. The
// pipeline takes one request every cycle and holds as a whole when the
// response side stalls. It has three stages of differences, products and
// determinant, one stage per quotient bit of the bit-serial multiply-divide
// that scales the crossing parameter, and one output register.
module segment_intersection_point_core
    import sip_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    sip_req_if.sink        req,
    sip_rsp_if.source      rsp
);

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int DW = 2 * C + 2;
    localparam int QW = C + F + 1;

    logic en;
    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;

    logic [FIELD_W-1:0] coord_in [NUM_COORDS];
    assign coord_in[0] = req.a_start_x;
    assign coord_in[1] = req.a_start_y;
    assign coord_in[2] = req.a_end_x;
    assign coord_in[3] = req.a_end_y;
    assign coord_in[4] = req.b_start_x;
    assign coord_in[5] = req.b_start_y;
    assign coord_in[6] = req.b_end_x;
    assign coord_in[7] = req.b_end_y;

    logic                valid_d [QW+1];
    logic [DW-1:0]       tn_d    [QW+1];
    logic [DW-1:0]       den_d   [QW+1];
    logic [QW-1:0]       m_x_d   [QW+1];
    logic [QW-1:0]       m_y_d   [QW+1];
    logic [QW-1:0]       q_x_d   [QW+1];
    logic [QW-1:0]       q_y_d   [QW+1];
    logic [DW-1:0]       r_x_d   [QW+1];
    logic [DW-1:0]       r_y_d   [QW+1];
    logic                neg_x_d [QW+1];
    logic                neg_y_d [QW+1];
    logic signed [C-1:0] bx_d    [QW+1];
    logic signed [C-1:0] by_d    [QW+1];
    logic                fnd_d   [QW+1];

    logic [C:0] mag_x, mag_y;

    sip_front #(
        .C (C)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .coord_in  (coord_in),
        .out_valid (valid_d[0]),
        .tn        (tn_d[0]),
        .den       (den_d[0]),
        .mag_x     (mag_x),
        .mag_y     (mag_y),
        .neg_x     (neg_x_d[0]),
        .neg_y     (neg_y_d[0]),
        .base_x    (bx_d[0]),
        .base_y    (by_d[0]),
        .found     (fnd_d[0])
    );

    // multiplier is |delta| scaled by 2^F
    assign m_x_d[0] = QW'(mag_x) << F;
    assign m_y_d[0] = QW'(mag_y) << F;
    assign q_x_d[0] = '0;
    assign q_y_d[0] = '0;
    assign r_x_d[0] = '0;
    assign r_y_d[0] = '0;

    for (genvar k = 0; k < QW; k++) begin : g_div
        sip_div_stage #(
            .C (C),
            .F (F)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .in_valid   (valid_d[k]),
            .in_tn      (tn_d[k]),
            .in_den     (den_d[k]),
            .in_m_x     (m_x_d[k]),
            .in_m_y     (m_y_d[k]),
            .in_q_x     (q_x_d[k]),
            .in_q_y     (q_y_d[k]),
            .in_r_x     (r_x_d[k]),
            .in_r_y     (r_y_d[k]),
            .in_neg_x   (neg_x_d[k]),
            .in_neg_y   (neg_y_d[k]),
            .in_base_x  (bx_d[k]),
            .in_base_y  (by_d[k]),
            .in_found   (fnd_d[k]),
            .out_valid  (valid_d[k+1]),
            .out_tn     (tn_d[k+1]),
            .out_den    (den_d[k+1]),
            .out_m_x    (m_x_d[k+1]),
            .out_m_y    (m_y_d[k+1]),
            .out_q_x    (q_x_d[k+1]),
            .out_q_y    (q_y_d[k+1]),
            .out_r_x    (r_x_d[k+1]),
            .out_r_y    (r_y_d[k+1]),
            .out_neg_x  (neg_x_d[k+1]),
            .out_neg_y  (neg_y_d[k+1]),
            .out_base_x (bx_d[k+1]),
            .out_base_y (by_d[k+1]),
            .out_found  (fnd_d[k+1])
        );
    end

    sip_fix_out #(
        .C (C),
        .F (F)
    ) u_fix_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_d[QW]),
        .q_x       (q_x_d[QW]),
        .q_y       (q_y_d[QW]),
        .r_x       (r_x_d[QW]),
        .r_y       (r_y_d[QW]),
        .neg_x     (neg_x_d[QW]),
        .neg_y     (neg_y_d[QW]),
        .base_x    (bx_d[QW]),
        .base_y    (by_d[QW]),
        .in_found  (fnd_d[QW]),
        .out_valid (rsp.valid),
        .found     (rsp.found),
        .point_x   (rsp.point_x),
        .point_y   (rsp.point_y)
    );

    // tn/den/m leave the last stage unused
    logic unused_tail;
    assign unused_tail = ^{tn_d[QW], den_d[QW], m_x_d[QW], m_y_d[QW]};

endmodule

[rtl/core/sip_front.sv]
module sip_front
    import sip_pkg::*;
#(
    parameter int C = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [FIELD_W-1:0]   coord_in [NUM_COORDS],
    output logic                 out_valid,
    output logic [2*C+1:0]       tn,
    output logic [2*C+1:0]       den,
    output logic [C:0]           mag_x,
    output logic [C:0]           mag_y,
    output logic                 neg_x,
    output logic                 neg_y,
    output logic signed [C-1:0]  base_x,
    output logic signed [C-1:0]  base_y,
    output logic                 found
);

    localparam int DF = C + 1;
    localparam int PW = 2 * C + 2;
    localparam int SW = 2 * C + 3;
    localparam int DW = 2 * C + 2;

    logic signed [C-1:0] c [NUM_COORDS];

    for (genvar i = 0; i < NUM_COORDS; i++) begin : g_coord
        if (C <= FIELD_W) begin : g_trunc
            assign c[i] = coord_in[i][C-1:0];
        end else begin : g_ext
            assign c[i] = {{(C-FIELD_W){1'b0}}, coord_in[i]};
        end
    end

    // Stage A: differences and shared-endpoint flags
    logic                 valid_a_reg;
    logic signed [C-1:0]  x1_a_reg, y1_a_reg, x2_a_reg, y2_a_reg;
    logic signed [DF-1:0] rx_a_reg, ry_a_reg, sx_a_reg, sy_a_reg, qx_a_reg, qy_a_reg;
    logic                 eq1_a_reg, eq2_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end else if (en)
        begin
            valid_a_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_a_reg  <= c[0];
            y1_a_reg  <= c[1];
            x2_a_reg  <= c[2];
            y2_a_reg  <= c[3];
            rx_a_reg  <= DF'(c[2]) - DF'(c[0]);
            ry_a_reg  <= DF'(c[3]) - DF'(c[1]);
            sx_a_reg  <= DF'(c[6]) - DF'(c[4]);
            sy_a_reg  <= DF'(c[7]) - DF'(c[5]);
            qx_a_reg  <= DF'(c[4]) - DF'(c[0]);
            qy_a_reg  <= DF'(c[5]) - DF'(c[1]);
            eq1_a_reg <= (c[0] == c[4] && c[1] == c[5]) || (c[0] == c[6] && c[1] == c[7]);
            eq2_a_reg <= (c[2] == c[4] && c[3] == c[5]) || (c[2] == c[6] && c[3] == c[7]);
        end
    end

    // Stage B: cross products
    logic                 valid_b_reg;
    logic signed [C-1:0]  x1_b_reg, y1_b_reg, x2_b_reg, y2_b_reg;
    logic signed [DF-1:0] rx_b_reg, ry_b_reg;
    logic signed [PW-1:0] rxsy_b_reg, rysx_b_reg, qxsy_b_reg, qysx_b_reg;
    logic signed [PW-1:0] qxry_b_reg, qyrx_b_reg;
    logic                 eq1_b_reg, eq2_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
        end else if (en)
        begin
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_b_reg   <= x1_a_reg;
            y1_b_reg   <= y1_a_reg;
            x2_b_reg   <= x2_a_reg;
            y2_b_reg   <= y2_a_reg;
            rx_b_reg   <= rx_a_reg;
            ry_b_reg   <= ry_a_reg;
            eq1_b_reg  <= eq1_a_reg;
            eq2_b_reg  <= eq2_a_reg;
            rxsy_b_reg <= PW'(rx_a_reg) * PW'(sy_a_reg);
            rysx_b_reg <= PW'(ry_a_reg) * PW'(sx_a_reg);
            qxsy_b_reg <= PW'(qx_a_reg) * PW'(sy_a_reg);
            qysx_b_reg <= PW'(qy_a_reg) * PW'(sx_a_reg);
            qxry_b_reg <= PW'(qx_a_reg) * PW'(ry_a_reg);
            qyrx_b_reg <= PW'(qy_a_reg) * PW'(rx_a_reg);
        end
    end

    // Stage C: determinant, sign fix, box check, case select
    logic signed [SW-1:0] den_s, tn_s, un_s, den_abs, tn_fix, un_fix;
    logic                 den_neg, in_box, found_next;
    logic [DW-1:0]        tn_next, den_next;
    logic [DF-1:0]        mag_x_next, mag_y_next;
    logic                 neg_x_next, neg_y_next;
    logic signed [C-1:0]  base_x_next, base_y_next;

    always_comb
    begin
        den_s   = SW'(rxsy_b_reg) - SW'(rysx_b_reg);
        tn_s    = SW'(qxsy_b_reg) - SW'(qysx_b_reg);
        un_s    = SW'(qxry_b_reg) - SW'(qyrx_b_reg);
        den_neg = den_s < 0;
        den_abs = den_neg ? -den_s : den_s;
        tn_fix  = den_neg ? -tn_s : tn_s;
        un_fix  = den_neg ? -un_s : un_s;
        in_box  = (tn_fix >= 0) && (tn_fix <= den_abs) && (un_fix >= 0) && (un_fix <= den_abs);

        found_next  = (den_s != 0) && (eq1_b_reg || eq2_b_reg || in_box);
        base_x_next = x1_b_reg;
        base_y_next = y1_b_reg;
        tn_next     = '0;
        den_next    = DW'(1);
        mag_x_next  = '0;
        mag_y_next  = '0;
        neg_x_next  = 1'b0;
        neg_y_next  = 1'b0;
        if (eq1_b_reg)
        begin
            // exact shared endpoint: keep defaults
        end else if (eq2_b_reg)
        begin
            base_x_next = x2_b_reg;
            base_y_next = y2_b_reg;
        end else if (found_next)
        begin
            tn_next    = tn_fix[DW-1:0];
            den_next   = den_abs[DW-1:0];
            mag_x_next = rx_b_reg < 0 ? DF'(-rx_b_reg) : DF'(rx_b_reg);
            mag_y_next = ry_b_reg < 0 ? DF'(-ry_b_reg) : DF'(ry_b_reg);
            neg_x_next = rx_b_reg < 0;
            neg_y_next = ry_b_reg < 0;
        end
    end

    logic valid_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_c_reg <= 1'b0;
        end else if (en)
        begin
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tn     <= tn_next;
            den    <= den_next;
            mag_x  <= mag_x_next;
            mag_y  <= mag_y_next;
            neg_x  <= neg_x_next;
            neg_y  <= neg_y_next;
            base_x <= base_x_next;
            base_y <= base_y_next;
            found  <= found_next;
        end
    end

    assign out_valid = valid_c_reg;

endmodule

[rtl/core/sip_div_stage.sv]
module sip_div_stage
    import sip_pkg::*;
#(
    parameter int C = 16,
    parameter int F = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [2*C+1:0]           in_tn,
    input  logic [2*C+1:0]           in_den,
    input  logic [C+F:0]             in_m_x,
    input  logic [C+F:0]             in_m_y,
    input  logic [C+F:0]             in_q_x,
    input  logic [C+F:0]             in_q_y,
    input  logic [2*C+1:0]           in_r_x,
    input  logic [2*C+1:0]           in_r_y,
    input  logic                     in_neg_x,
    input  logic                     in_neg_y,
    input  logic signed [C-1:0]      in_base_x,
    input  logic signed [C-1:0]      in_base_y,
    input  logic                     in_found,
    output logic                     out_valid,
    output logic [2*C+1:0]           out_tn,
    output logic [2*C+1:0]           out_den,
    output logic [C+F:0]             out_m_x,
    output logic [C+F:0]             out_m_y,
    output logic [C+F:0]             out_q_x,
    output logic [C+F:0]             out_q_y,
    output logic [2*C+1:0]           out_r_x,
    output logic [2*C+1:0]           out_r_y,
    output logic                     out_neg_x,
    output logic                     out_neg_y,
    output logic signed [C-1:0]      out_base_x,
    output logic signed [C-1:0]      out_base_y,
    output logic                     out_found
);

    localparam int DW = 2 * C + 2;
    localparam int QW = C + F + 1;

    // One multiplier bit: r <- 2r + bit*tn, then take out 0, 1 or 2 times den.
    // r stays below den, so the new digit is at most 2.
    function automatic logic [QW+DW-1:0] div_step(
        input logic [QW-1:0] q,
        input logic [DW-1:0] r,
        input logic          b,
        input logic [DW-1:0] t,
        input logic [DW-1:0] d
    );
        logic [DW+1:0] r2;
        logic [DW+1:0] d1;
        logic [DW+1:0] d2;
        logic [DW+1:0] rn;
        logic [1:0]    dig;
        logic [QW-1:0] qn;
        r2 = {1'b0, r, 1'b0} + (b ? {2'b00, t} : '0);
        d1 = {2'b00, d};
        d2 = {1'b0, d, 1'b0};
        if (r2 >= d2)
        begin
            rn  = r2 - d2;
            dig = 2'd2;
        end else if (r2 >= d1)
        begin
            rn  = r2 - d1;
            dig = 2'd1;
        end else
        begin
            rn  = r2;
            dig = 2'd0;
        end
        qn = {q[QW-2:0], 1'b0} + {{(QW-2){1'b0}}, dig};
        return {qn, rn[DW-1:0]};
    endfunction

    logic [QW+DW-1:0] step_x, step_y;

    assign step_x = div_step(in_q_x, in_r_x, in_m_x[QW-1], in_tn, in_den);
    assign step_y = div_step(in_q_y, in_r_y, in_m_y[QW-1], in_tn, in_den);

    logic valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_tn     <= in_tn;
            out_den    <= in_den;
            out_m_x    <= {in_m_x[QW-2:0], 1'b0};
            out_m_y    <= {in_m_y[QW-2:0], 1'b0};
            out_q_x    <= step_x[QW+DW-1:DW];
            out_q_y    <= step_y[QW+DW-1:DW];
            out_r_x    <= step_x[DW-1:0];
            out_r_y    <= step_y[DW-1:0];
            out_neg_x  <= in_neg_x;
            out_neg_y  <= in_neg_y;
            out_base_x <= in_base_x;
            out_base_y <= in_base_y;
            out_found  <= in_found;
        end
    end

    assign out_valid = valid_reg;

endmodule

[rtl/core/sip_fix_out.sv]
module sip_fix_out
    import sip_pkg::*;
#(
    parameter int C = 16,
    parameter int F = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [C+F:0]            q_x,
    input  logic [C+F:0]            q_y,
    input  logic [2*C+1:0]          r_x,
    input  logic [2*C+1:0]          r_y,
    input  logic                    neg_x,
    input  logic                    neg_y,
    input  logic signed [C-1:0]     base_x,
    input  logic signed [C-1:0]     base_y,
    input  logic                    in_found,
    output logic                    out_valid,
    output logic                    found,
    output logic [POINT_W-1:0]      point_x,
    output logic [POINT_W-1:0]      point_y
);

    localparam int VW = (C + F + 3 > POINT_W + 1) ? C + F + 3 : POINT_W + 1;

    function automatic logic [POINT_W-1:0] to_fixed(
        input logic signed [C-1:0] base,
        input logic [C+F:0]        q,
        input logic                rem_nz,
        input logic                neg
    );
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] off;
        logic signed [VW-1:0] hi_lim;
        logic signed [VW-1:0] lo_lim;
        hi_lim = {{(VW-POINT_W+1){1'b0}}, {(POINT_W-1){1'b1}}};
        lo_lim = {{(VW-POINT_W+1){1'b1}}, {(POINT_W-1){1'b0}}};
        // negative offsets round toward minus infinity
        off = neg ? -(VW'(q) + VW'(rem_nz)) : VW'(q);
        v   = (VW'(base) <<< F) + off;
        if (v > hi_lim)
        begin
            v = hi_lim;
        end else if (v < lo_lim)
        begin
            v = lo_lim;
        end
        return v[POINT_W-1:0];
    endfunction

    logic valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            found   <= in_found;
            point_x <= in_found ? to_fixed(base_x, q_x, r_x != '0, neg_x) : '0;
            point_y <= in_found ? to_fixed(base_y, q_y, r_y != '0, neg_y) : '0;
        end
    end

    assign out_valid = valid_reg;

endmodule

[tb/sip_checker.sv]
module sip_checker
    import sip_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sip_req_if        req,
    sip_rsp_if        rsp,
    output int        fail_count,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               found;
        logic [POINT_W-1:0] point_x;
        logic [POINT_W-1:0] point_y;
    } point_t;

    point_t expected_points[$];

    // base * 2^16 + floor(tn * delta * 2^16 / den), saturated to 32 bits
    function automatic logic [POINT_W-1:0] fixed_coord(longint base, longint delta,
                                                       longint tn, longint den);
        logic signed [127:0] num;
        logic signed [127:0] q;
        logic signed [127:0] v;
        num = tn;
        num = num * delta;
        num = num <<< 16;
        q = num / den;
        if (num < 0 && q * den != num)
            q = q - 1;
        v = base;
        v = (v <<< 16) + q;
        if (v > 128'sd2147483647)
            v = 128'sd2147483647;
        if (v < -128'sd2147483648)
            v = -128'sd2147483648;
        return v[POINT_W-1:0];
    endfunction

    function automatic point_t crossing_point(input logic signed [FIELD_W-1:0] c[8]);
        point_t r;
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint rx, ry, sx, sy, qx, qy, den, tn, un;
        x1 = c[0]; y1 = c[1]; x2 = c[2]; y2 = c[3];
        x3 = c[4]; y3 = c[5]; x4 = c[6]; y4 = c[7];
        rx = x2 - x1; ry = y2 - y1;
        sx = x4 - x3; sy = y4 - y3;
        qx = x3 - x1; qy = y3 - y1;
        den = rx * sy - ry * sx;
        r = '0;
        if (den == 0)
            return r;
        if ((x1 == x3 && y1 == y3) || (x1 == x4 && y1 == y4)) begin
            r.found = 1'b1;
            r.point_x = fixed_coord(x1, 0, 0, 1);
            r.point_y = fixed_coord(y1, 0, 0, 1);
            return r;
        end
        if ((x2 == x3 && y2 == y3) || (x2 == x4 && y2 == y4)) begin
            r.found = 1'b1;
            r.point_x = fixed_coord(x2, 0, 0, 1);
            r.point_y = fixed_coord(y2, 0, 0, 1);
            return r;
        end
        tn = qx * sy - qy * sx;
        un = qx * ry - qy * rx;
        if (den < 0) begin
            den = -den; tn = -tn; un = -un;
        end
        if (tn < 0 || tn > den || un < 0 || un > den)
            return r;
        r.found = 1'b1;
        r.point_x = fixed_coord(x1, rx, tn, den);
        r.point_y = fixed_coord(y1, ry, tn, den);
        return r;
    endfunction

    initial fail_count = 0;
    assign pending = expected_points.size();

    always @(posedge clk) begin
        logic signed [FIELD_W-1:0] c[8];
        point_t want;
        if (rst_n) begin
            if (req.valid && req.ready) begin
                c[0] = req.a_start_x; c[1] = req.a_start_y;
                c[2] = req.a_end_x;   c[3] = req.a_end_y;
                c[4] = req.b_start_x; c[5] = req.b_start_y;
                c[6] = req.b_end_x;   c[7] = req.b_end_y;
                expected_points.push_back(crossing_point(c));
            end
            if (rsp.valid && rsp.ready) begin
                if (expected_points.size() == 0) begin
                    $error("unexpected response transfer");
                    fail_count++;
                end else begin
                    want = expected_points.pop_front();
                    if (rsp.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, rsp.found);
                        fail_count++;
                    end
                    if (rsp.point_x !== want.point_x) begin
                        $error("point_x: expected %h, got %h", want.point_x, rsp.point_x);
                        fail_count++;
                    end
                    if (rsp.point_y !== want.point_y) begin
                        $error("point_y: expected %h, got %h", want.point_y, rsp.point_y);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

[tb/testbench.sv]
module testbench;
    import sip_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1500;
    localparam int IDLE_LIMIT   = 3000;
    localparam int LONG_HOLD    = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    logic hold_rsp = 1'b0;
    int   idle_cycles = 0;

    sip_req_if req ();
    sip_rsp_if rsp ();

    segment_intersection_point_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    sip_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        req.valid = 1'b0;
        {req.a_start_x, req.a_start_y, req.a_end_x, req.a_end_y} = '0;
        {req.b_start_x, req.b_start_y, req.b_end_x, req.b_end_y} = '0;
        rsp.ready = 1'b0;
    end

    // Receiver: ready pattern changes mode every so often; one long hold on request
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rsp) begin
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_rsp = 1'b0;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= ($urandom_range(0, 9) < 7);
                2: rsp.ready <= ($urandom_range(0, 9) < 2);
                default: rsp.ready <= (left % 4 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    int burst_left = 0;

    task automatic send_segments(input logic [15:0] ax1, ay1, ax2, ay2,
                                 input logic [15:0] bx1, by1, bx2, by2);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req.valid <= 1'b1;
        req.a_start_x <= ax1; req.a_start_y <= ay1;
        req.a_end_x   <= ax2; req.a_end_y   <= ay2;
        req.b_start_x <= bx1; req.b_start_y <= by1;
        req.b_end_x   <= bx2; req.b_end_y   <= by2;
        do @(posedge clk); while (!req.ready);
    endtask

    function automatic logic [15:0] rnd_coord(input int span);
        if (span == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 2 * span) - span);
    endfunction

    initial
    begin
        logic [15:0] c[8];
        int kind;
        int span;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain crossing, negative deltas, misses, parallel and degenerate cases
        send_segments(0, 0, 10, 10, 0, 10, 10, 0);
        send_segments(10, 10, 0, 0, 10, 0, 0, 10);
        send_segments(0, 0, 3, 1, 0, 1, 1, 0);
        send_segments(-5, 7, 4, -9, -6, -3, 8, 2);
        send_segments(0, 0, 1, 1, 5, 0, 0, 5);
        send_segments(0, 0, 10, 0, 0, 5, 10, 5);
        send_segments(0, 0, 10, 0, 2, 0, 8, 0);
        send_segments(0, 0, 10, 0, 10, 0, 20, 0);
        send_segments(3, 3, 3, 3, 0, 0, 5, 7);
        // shared endpoints in every pairing
        send_segments(1, 2, 5, 9, 1, 2, -4, 6);
        send_segments(1, 2, 5, 9, -4, 6, 1, 2);
        send_segments(1, 2, 5, 9, 5, 9, 7, -3);
        send_segments(1, 2, 5, 9, 7, -3, 5, 9);
        // T-junction: B starts in the middle of A
        send_segments(0, 0, 10, 0, 5, 0, 5, 8);
        // extremes of the coordinate range
        send_segments(16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                      16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_segments(16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                      16'h8000, 16'h8000, 16'h7fff, 16'h7ffe);
        send_segments(16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                      16'h8000, 16'h8000, 16'h8000, 16'h7fff);
        send_segments(16'h8000, 0, 16'h7fff, 1, 0, 16'h8000, 1, 16'h7fff);
        send_segments(16'hffff, 16'hffff, 16'h0001, 16'h0001,
                      16'hffff, 16'h0001, 16'h0001, 16'hffff);

        // let the output side block for a long stretch while requests keep coming
        hold_rsp = 1'b1;

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2) begin
                req.valid <= 1'b0;
                burst_left = 0;
                do @(posedge clk); while (pending != 0);
            end
            kind = $urandom_range(0, 9);
            span = ($urandom_range(0, 3) == 0) ? 0 : ($urandom_range(0, 1) ? 20 : 3000);
            foreach (c[i]) c[i] = rnd_coord(span);
            case (kind)
                0: begin c[4] = c[0]; c[5] = c[1]; end
                1: begin c[6] = c[0]; c[7] = c[1]; end
                2: begin c[4] = c[2]; c[5] = c[3]; end
                3: begin c[6] = c[2]; c[7] = c[3]; end
                4: begin
                    // parallel: B is A shifted
                    c[6] = c[4] + c[2] - c[0];
                    c[7] = c[5] + c[3] - c[1];
                end
                5: begin c[2] = c[0]; c[3] = c[1]; end
                default: ;
            endcase
            send_segments(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
        end
        req.valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[sim.f]
rtl/core/sip_pkg.sv
rtl/core/sip_if.sv
rtl/core/sip_front.sv
rtl/core/sip_div_stage.sv
rtl/core/sip_fix_out.sv
rtl/core/segment_intersection_point_core.sv
tb/sip_checker.sv
tb/testbench.sv
